>>> hw/rtl/maema_pkg.sv
// Shared constants and register codes for the flex-sensor averaging and angle filter.
package maema_pkg;

    // Fixed field widths
    localparam int CAL_W      = 12;     // calibration points
    localparam int ALPHA_W    = 17;     // EMA weight, Q0.16 with 1.0 representable
    localparam int NORM_W     = 17;     // normalized position, Q0.16 with 1.0
    localparam int ANGLE_W    = 15;     // angle, Q7.8 degrees
    localparam int FRAC_W     = 8;      // fraction bits of the averaged value
    localparam int NORM_FRAC  = 16;     // quotient bits of the normalize divide

    localparam logic [ALPHA_W-1:0] ONE_Q16     = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
    localparam logic [CAL_W-1:0]   CAL_MIN_RESET = 12'd0;
    localparam logic [CAL_W-1:0]   CAL_MAX_RESET = 12'd4095;
    localparam logic [6:0]         ANGLE_SCALE   = 7'd90;

    // APB register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_ALPHA     = 2'd0;
    localparam logic [1:0] REG_CAL_MIN   = 2'd1;
    localparam logic [1:0] REG_CAL_MAX   = 2'd2;
    localparam logic [1:0] REG_CAL_VALID = 2'd3;

endpackage

>>> hw/rtl/maema_div.sv
// Shared restoring divider, one quotient bit per cycle.
module maema_div
    import maema_pkg::*;
#(
    parameter int NUM_W  = 23,
    parameter int DEN_W  = 12,
    parameter int STEP_W = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [STEP_W-1:0] steps,
    input  logic [DEN_W-1:0]  rem_init,
    input  logic [NUM_W-1:0]  num_init,
    input  logic [DEN_W-1:0]  den,
    output logic              busy,
    output logic [NUM_W-1:0]  quotient
);

    logic [STEP_W-1:0] count_reg, count_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_sub;
    logic              fits;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        num_next  = {num_reg[NUM_W-2:0], fits};
        count_next = count_reg - STEP_W'(1);
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (start)
        begin
            count_reg <= steps;
        end
        else if (busy)
        begin
            count_reg <= count_next;
        end
    end

    // Remainder and numerator/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            num_reg <= num_init;
            den_reg <= den;
        end
        else if (busy)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign busy     = (count_reg != '0);
    assign quotient = num_reg;

endmodule

>>> hw/rtl/moving_average_ema_angle_filter_top.sv
// Top level of the flex-sensor moving average, EMA and bend-angle filter.
//
// Usage:
//   Input channel carries one raw_sample word per item (in_valid/in_stall).
//   Output channel carries one result word per item: filtered_value (Q12.8),
//   normalized (Q0.16), angle (Q7.8 degrees) and calib_used (out_valid/out_stall).
//   Registers sit on an APB port: alpha at 0x0, cal_min at 0x4, cal_max at 0x8,
//   cal_valid at 0xC. Write them only while the filter is idle.
// Timing:
//   One item at a time. The shared bit-serial divider is used once for the
//   window average and, when calibrated and not clamped, once for
//   normalization; the EMA loads the average directly while it is zero.
//   The sample ring is a one-port-read synchronous memory whose read is
//   registered as the word is taken.
//   in_stall is low only while the sequencer is idle; a finished word waits in
//   the output register, so the next sample is taken while the receiver stalls.
//   A stalled output word holds until out_stall drops.
// Reset:
//   Clears ring fill count, write pointer, running sum and EMA, and loads the
//   register defaults. No clearing pass: the fill count makes unfilled ring entries count as zero.
module moving_average_ema_angle_filter_top
    import maema_pkg::*;
#(
    parameter int WINDOW_SIZE = 8,
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // sample input
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [SAMPLE_BITS-1:0]      raw_sample,
    // result output
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [SAMPLE_BITS+FRAC_W-1:0] filtered_value,
    output logic [NORM_W-1:0]           normalized,
    output logic [ANGLE_W-1:0]          angle,
    output logic                        calib_used,
    // APB register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int IDX_W     = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W     = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW_SIZE);
    localparam int FILT_W    = SAMPLE_BITS + FRAC_W;
    localparam int DIV_NUM_W = SUM_W + FRAC_W;
    localparam int DEN_W     = (CNT_W > CAL_W) ? CNT_W : CAL_W;
    localparam int STEP_W    = $clog2(DIV_NUM_W + 1);
    localparam int CMP_W     = (FILT_W > CAL_W + FRAC_W) ? FILT_W : CAL_W + FRAC_W;
    localparam int PROD_W    = ALPHA_W + FILT_W + 2;

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RD      = 3'd1;
    localparam logic [2:0] S_AVG     = 3'd2;
    localparam logic [2:0] S_EMA_MUL = 3'd3;
    localparam logic [2:0] S_EMA_ADD = 3'd4;
    localparam logic [2:0] S_NORM    = 3'd5;
    localparam logic [2:0] S_NDIV    = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    // Registers
    logic [2:0]              state_reg, state_next;
    logic [ALPHA_W-1:0]      alpha_reg;
    logic [CAL_W-1:0]        cal_min_reg;
    logic [CAL_W-1:0]        cal_max_reg;
    logic                    cal_valid_reg;
    logic [IDX_W-1:0]        widx_reg, widx_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [FILT_W-1:0]       ema_reg, ema_next;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SAMPLE_BITS-1:0]  rd_data_reg;
    logic [FILT_W-1:0]       avg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [NORM_W-1:0]       norm_reg, norm_next;
    logic                    used_reg, used_next;
    logic                    out_valid_reg, out_valid_next;
    logic [FILT_W-1:0]       filt_out_reg;
    logic [NORM_W-1:0]       norm_out_reg;
    logic [ANGLE_W-1:0]      angle_out_reg;
    logic                    used_out_reg;

    // Sample ring memory
    logic [SAMPLE_BITS-1:0]  ring_mem [WINDOW_SIZE];

    // Combinational helpers
    logic                    in_take;
    logic                    out_free;
    logic [SAMPLE_BITS-1:0]  old_sample;
    logic [SUM_W-1:0]        sum_upd;
    logic [CNT_W-1:0]        fill_upd;
    logic [ALPHA_W-1:0]      alpha_eff;
    logic signed [FILT_W:0]  ema_diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] ema_sum;
    logic                    calib_ok;
    logic [CAL_W-1:0]        cal_range;
    logic [CMP_W-1:0]        cal_base;
    logic [CMP_W-1:0]        filt_cmp;
    logic [CMP_W-1:0]        norm_diff;
    logic [CMP_W-1:0]        range_sh;
    logic [NORM_W+6:0]       angle_full;
    logic                    cfg_write;

    // Divider interface
    logic                    div_start;
    logic [STEP_W-1:0]       div_steps;
    logic [DEN_W-1:0]        div_rem_init;
    logic [DIV_NUM_W-1:0]    div_num_init;
    logic [DEN_W-1:0]        div_den;
    logic                    div_busy;
    logic [DIV_NUM_W-1:0]    div_quotient;

    maema_div #(
        .NUM_W  (DIV_NUM_W),
        .DEN_W  (DEN_W),
        .STEP_W (STEP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .rem_init (div_rem_init),
        .num_init (div_num_init),
        .den      (div_den),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Handshakes
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= ALPHA_RESET;
            cal_min_reg   <= CAL_MIN_RESET;
            cal_max_reg   <= CAL_MAX_RESET;
            cal_valid_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ALPHA:     alpha_reg     <= pwdata[ALPHA_W-1:0];
                REG_CAL_MIN:   cal_min_reg   <= pwdata[CAL_W-1:0];
                REG_CAL_MAX:   cal_max_reg   <= pwdata[CAL_W-1:0];
                REG_CAL_VALID: cal_valid_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_ALPHA:     prdata = APB_DATA_W'(alpha_reg);
            REG_CAL_MIN:   prdata = APB_DATA_W'(cal_min_reg);
            REG_CAL_MAX:   prdata = APB_DATA_W'(cal_max_reg);
            REG_CAL_VALID: prdata = APB_DATA_W'(cal_valid_reg);
            default:       prdata = '0;
        endcase
    end

    // Ring memory: read on acceptance, write back the new sample in S_RD, the cycle after
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rd_data_reg <= ring_mem[widx_reg];
        end
        if (state_reg == S_RD)
        begin
            ring_mem[widx_reg] <= sample_reg;
        end
    end

    // Running sum update; entries beyond the fill count were never written
    always_comb
    begin
        old_sample = (fill_reg < CNT_W'(WINDOW_SIZE)) ? '0 : rd_data_reg;
        sum_upd    = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
        fill_upd   = (fill_reg < CNT_W'(WINDOW_SIZE)) ? fill_reg + CNT_W'(1) : fill_reg;
    end

    // EMA: ema + a*(avg - ema) / 2^16, weight saturated at one
    always_comb
    begin
        alpha_eff = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
        ema_diff  = $signed({1'b0, avg_reg}) - $signed({1'b0, ema_reg});
        prod_next = PROD_W'($signed({1'b0, alpha_eff}) * ema_diff);
        ema_sum   = $signed({{(PROD_W-FILT_W){1'b0}}, ema_reg}) + (prod_reg >>> NORM_FRAC);
    end

    // Calibration checks
    always_comb
    begin
        calib_ok  = cal_valid_reg && (cal_max_reg > cal_min_reg);
        cal_range = cal_max_reg - cal_min_reg;
        cal_base  = CMP_W'({cal_min_reg, {FRAC_W{1'b0}}});
        filt_cmp  = CMP_W'(ema_reg);
        norm_diff = filt_cmp - cal_base;
        range_sh  = CMP_W'({cal_range, {FRAC_W{1'b0}}});
    end

    // Angle = norm * 90 / 256
    assign angle_full = {7'b0, norm_reg} * ANGLE_SCALE;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        ema_next       = ema_reg;
        norm_next      = norm_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;
        div_steps      = STEP_W'(DIV_NUM_W);
        div_rem_init   = '0;
        div_num_init   = {sum_upd, {FRAC_W{1'b0}}};
        div_den        = DEN_W'(fill_upd);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                sum_next   = sum_upd;
                fill_next  = fill_upd;
                widx_next  = (widx_reg == IDX_W'(WINDOW_SIZE - 1)) ? '0 : widx_reg + IDX_W'(1);
                div_start  = 1'b1;
                state_next = S_AVG;
            end
            S_AVG:
            begin
                if (!div_busy)
                begin
                    state_next = S_EMA_MUL;
                end
            end
            S_EMA_MUL:
            begin
                if (ema_reg == '0)
                begin
                    ema_next   = avg_reg;
                    state_next = S_NORM;
                end
                else
                begin
                    state_next = S_EMA_ADD;
                end
            end
            S_EMA_ADD:
            begin
                ema_next   = ema_sum[FILT_W-1:0];
                state_next = S_NORM;
            end
            S_NORM:
            begin
                used_next  = calib_ok;
                norm_next  = '0;
                state_next = S_DONE;
                if (calib_ok && (filt_cmp > cal_base))
                begin
                    if (norm_diff >= range_sh)
                    begin
                        norm_next = ONE_Q16;
                    end
                    else
                    begin
                        // quotient < 2^16 here, so the high part is below the range
                        div_start    = 1'b1;
                        div_steps    = STEP_W'(NORM_FRAC);
                        div_rem_init = DEN_W'(norm_diff >> FRAC_W);
                        div_num_init = DIV_NUM_W'({norm_diff[FRAC_W-1:0], {FRAC_W{1'b0}}})
                                       << (DIV_NUM_W - NORM_FRAC);
                        div_den      = DEN_W'(cal_range);
                        state_next   = S_NDIV;
                    end
                end
            end
            S_NDIV:
            begin
                if (!div_busy)
                begin
                    norm_next  = NORM_W'(div_quotient[NORM_FRAC-1:0]);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            widx_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            ema_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            ema_reg       <= ema_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= raw_sample;
        end
        if (state_reg == S_AVG && !div_busy)
        begin
            avg_reg <= div_quotient[FILT_W-1:0];
        end
        if (state_reg == S_EMA_MUL)
        begin
            prod_reg <= prod_next;
        end
        norm_reg <= norm_next;
        used_reg <= used_next;
        if (state_reg == S_DONE && out_free)
        begin
            filt_out_reg  <= ema_reg;
            norm_out_reg  <= norm_reg;
            angle_out_reg <= angle_full[FRAC_W +: ANGLE_W];
            used_out_reg  <= used_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = filt_out_reg;
    assign normalized     = norm_out_reg;
    assign angle          = angle_out_reg;
    assign calib_used     = used_out_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_SIZE))
        else $error("fill count beyond window");

    a_take_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == S_RD)
        else $error("accepted word did not start ring read");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_ema_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EMA_MUL && state_reg != S_EMA_ADD) |=> $stable(ema_reg))
        else $error("EMA changed outside its update states");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result word raised outside completion");

endmodule
